@@ rtl/mba_pkg.sv @@
package mba_pkg;

  localparam int CHANNELS = 16;
  localparam int CIDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CH_W     = 4;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 8;
  localparam int WORD_W   = SUM_W + CNT_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [2:0] {
    REG_FIRST_CHANNEL      = 3'd0,
    REG_LAST_CHANNEL       = 3'd1,
    REG_AVERAGE_COUNT      = 3'd2,
    REG_RESTART_ENABLE     = 3'd3,
    REG_UNIFORM_CONTINUOUS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0]  first_channel;
    logic [CH_W-1:0]  last_channel;
    logic [CNT_W-1:0] average_count;
    logic             restart_enable;
    logic             uniform_continuous;
  } cfg_t;

  // word held between the read issue and the update stage
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample_first;
    logic [SAMPLE_W-1:0] sample_second;
    logic                first_valid;
    logic                second_valid;
  } item_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [CIDX_W-1:0] idx;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

endpackage

@@ rtl/multichannel_block_averager.sv @@
// Channel  Handshake                 Payload
// in       in_valid / in_ready       channel, sample_first, sample_second,
//                                    first_valid, second_valid
// out      out_valid / out_ready     out_channel, running_sum, sample_count,
//                                    frame_done, done_bank, restart_scan
// cfg      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One word per cycle unless the output stalls; words and results are registered.
// The rate is set by the single read-modify-write of one bank RAM entry per word,
// with the last write forwarded to cover back-to-back hits on one channel.
// Synchronous reset marks every accumulator empty and selects bank 0 at once.
// A stalled output holds the update stage; words out of channel range pass freely.
module multichannel_block_averager (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mba_pkg::ADDR_W-1:0]   paddr,
  input  logic [mba_pkg::DATA_W-1:0]   pwdata,
  output logic [mba_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mba_pkg::CH_W-1:0]     channel,
  input  logic [mba_pkg::SAMPLE_W-1:0] sample_first,
  input  logic [mba_pkg::SAMPLE_W-1:0] sample_second,
  input  logic                         first_valid,
  input  logic                         second_valid,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mba_pkg::CH_W-1:0]     out_channel,
  output logic [mba_pkg::SUM_W-1:0]    running_sum,
  output logic [mba_pkg::CNT_W-1:0]    sample_count,
  output logic                         frame_done,
  output logic                         done_bank,
  output logic                         restart_scan
);

  mba_pkg::cfg_t              cfg;
  mba_pkg::item_t             s1;
  mba_pkg::mem_wr_t           mem_wr;
  logic                       advance;
  logic                       accept;
  logic                       in_range;
  logic [mba_pkg::CIDX_W-1:0] rd_idx;
  logic [mba_pkg::WORD_W-1:0] rdata0, rdata1;

  mba_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = !s1.valid || advance;
  assign accept   = in_valid && in_ready;
  assign in_range = (channel >= cfg.first_channel) && (channel <= cfg.last_channel) &&
                    (32'(channel) < mba_pkg::CHANNELS);
  assign rd_idx   = mba_pkg::CIDX_W'(channel);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (accept) begin
      s1.valid         <= 1'b1;
      s1.hit           <= in_range;
      s1.channel       <= channel;
      s1.sample_first  <= sample_first;
      s1.sample_second <= sample_second;
      s1.first_valid   <= first_valid;
      s1.second_valid  <= second_valid;
    end else if (advance) begin
      s1.valid <= 1'b0;
    end
  end

  // both banks are read; the bank is picked once the previous word has settled it
  mba_bank_ram u_bank0 (
    .clk   (clk),
    .we    (mem_wr.en && !mem_wr.bank),
    .waddr (mem_wr.idx),
    .wdata (mem_wr.data),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (rdata0)
  );

  mba_bank_ram u_bank1 (
    .clk   (clk),
    .we    (mem_wr.en && mem_wr.bank),
    .waddr (mem_wr.idx),
    .wdata (mem_wr.data),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (rdata1)
  );

  mba_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .s1           (s1),
    .rdata0       (rdata0),
    .rdata1       (rdata1),
    .advance      (advance),
    .mem_wr       (mem_wr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .running_sum  (running_sum),
    .sample_count (sample_count),
    .frame_done   (frame_done),
    .done_bank    (done_bank),
    .restart_scan (restart_scan)
  );

endmodule

@@ rtl/mba_cfg_regs.sv @@
module mba_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mba_pkg::ADDR_W-1:0] paddr,
  input  logic [mba_pkg::DATA_W-1:0] pwdata,
  output logic [mba_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output mba_pkg::cfg_t              cfg
);

  mba_pkg::reg_idx_t reg_sel;
  logic              wr_en;

  assign reg_sel = mba_pkg::reg_idx_t'(paddr[mba_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_channel      <= '0;
      cfg.last_channel       <= 4'd15;
      cfg.average_count      <= 8'd1;
      cfg.restart_enable     <= 1'b0;
      cfg.uniform_continuous <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        mba_pkg::REG_FIRST_CHANNEL:
          cfg.first_channel <= pwdata[mba_pkg::CH_W-1:0];
        mba_pkg::REG_LAST_CHANNEL:
          cfg.last_channel <= pwdata[mba_pkg::CH_W-1:0];
        mba_pkg::REG_AVERAGE_COUNT:
          cfg.average_count <= pwdata[mba_pkg::CNT_W-1:0];
        mba_pkg::REG_RESTART_ENABLE:
          cfg.restart_enable <= pwdata[0];
        mba_pkg::REG_UNIFORM_CONTINUOUS:
          cfg.uniform_continuous <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      mba_pkg::REG_FIRST_CHANNEL:      prdata = mba_pkg::DATA_W'(cfg.first_channel);
      mba_pkg::REG_LAST_CHANNEL:       prdata = mba_pkg::DATA_W'(cfg.last_channel);
      mba_pkg::REG_AVERAGE_COUNT:      prdata = mba_pkg::DATA_W'(cfg.average_count);
      mba_pkg::REG_RESTART_ENABLE:     prdata = mba_pkg::DATA_W'(cfg.restart_enable);
      mba_pkg::REG_UNIFORM_CONTINUOUS: prdata = mba_pkg::DATA_W'(cfg.uniform_continuous);
      default:                         prdata = '0;
    endcase
  end

endmodule

@@ rtl/mba_bank_ram.sv @@
module mba_bank_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [mba_pkg::CIDX_W-1:0] waddr,
  input  logic [mba_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [mba_pkg::CIDX_W-1:0] raddr,
  output logic [mba_pkg::WORD_W-1:0] rdata
);

  logic [mba_pkg::WORD_W-1:0] mem [mba_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mba_accum.sv @@
module mba_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  mba_pkg::cfg_t                cfg,
  input  mba_pkg::item_t               s1,
  input  logic [mba_pkg::WORD_W-1:0]   rdata0,
  input  logic [mba_pkg::WORD_W-1:0]   rdata1,
  output logic                         advance,
  output mba_pkg::mem_wr_t             mem_wr,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mba_pkg::CH_W-1:0]     out_channel,
  output logic [mba_pkg::SUM_W-1:0]    running_sum,
  output logic [mba_pkg::CNT_W-1:0]    sample_count,
  output logic                         frame_done,
  output logic                         done_bank,
  output logic                         restart_scan
);

  logic                                write_bank;
  logic [1:0][mba_pkg::CHANNELS-1:0]   filled;

  // last write, covers the read issued on the same edge
  logic                                fwd_valid;
  logic                                fwd_bank;
  logic [mba_pkg::CIDX_W-1:0]          fwd_idx;
  logic [mba_pkg::WORD_W-1:0]          fwd_word;

  logic [mba_pkg::CIDX_W-1:0]          idx;
  logic                                fwd_hit;
  logic [mba_pkg::WORD_W-1:0]          word;
  logic                                empty;
  logic [mba_pkg::CNT_W:0]             avg9;
  logic [mba_pkg::CNT_W:0]             cnt_old;
  logic                                restart;
  logic [mba_pkg::SUM_W-1:0]           sum0, sum1, sum2;
  logic [mba_pkg::CNT_W-1:0]           cnt0, cnt1, cnt2;
  logic                                take1, take2;
  logic                                done;
  logic                                fire;

  always_comb begin
    idx     = mba_pkg::CIDX_W'(s1.channel);
    fwd_hit = fwd_valid && (fwd_bank == write_bank) && (fwd_idx == idx);
    word    = fwd_hit ? fwd_word : (write_bank ? rdata1 : rdata0);
    empty   = !filled[write_bank][idx] || (word == mba_pkg::EMPTY_WORD);
    avg9    = {1'b0, cfg.average_count};
    // count field holds count-1; an all-ones field reads as 256
    cnt_old = {1'b0, word[mba_pkg::WORD_W-1:mba_pkg::SUM_W]} + 9'd1;
    restart = empty || (cnt_old >= avg9);
    sum0    = restart ? '0 : word[mba_pkg::SUM_W-1:0];
    cnt0    = restart ? '0 : cnt_old[mba_pkg::CNT_W-1:0];

    take1   = s1.first_valid && (({1'b0, cnt0} + 9'd1) <= avg9);
    sum1    = take1 ? sum0 + mba_pkg::SUM_W'(s1.sample_first) : sum0;
    cnt1    = cnt0 + mba_pkg::CNT_W'(take1);

    take2   = s1.second_valid && (({1'b0, cnt1} + 9'd1) <= avg9);
    sum2    = take2 ? sum1 + mba_pkg::SUM_W'(s1.sample_second) : sum1;
    cnt2    = cnt1 + mba_pkg::CNT_W'(take2);

    done    = ({1'b0, cnt2} >= avg9) && (s1.channel == cfg.last_channel);
  end

  assign advance = !s1.hit || !out_valid || out_ready;
  assign fire    = s1.valid && s1.hit && advance;

  always_comb begin
    mem_wr.en   = fire;
    mem_wr.bank = write_bank;
    mem_wr.idx  = idx;
    mem_wr.data = {cnt2 - 8'd1, sum2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_bank <= 1'b0;
      filled     <= '0;
      fwd_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        filled[write_bank][idx] <= 1'b1;
        fwd_valid               <= 1'b1;
        out_valid               <= 1'b1;
        if (done) begin
          write_bank <= !write_bank;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fwd_bank     <= write_bank;
      fwd_idx      <= idx;
      fwd_word     <= mem_wr.data;
      out_channel  <= s1.channel;
      running_sum  <= sum2;
      sample_count <= cnt2;
      frame_done   <= done;
      done_bank    <= done && write_bank;
      restart_scan <= done && cfg.restart_enable && cfg.uniform_continuous;
    end
  end

  a_bank_flip_on_done: assert property (@(posedge clk) disable iff (rst)
    (write_bank != $past(write_bank)) |-> $past(fire && done))
    else $error("write bank flipped without a completed frame");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_count <= cfg.average_count))
    else $error("sample count above average count");

  a_done_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> (sample_count == cfg.average_count))
    else $error("frame published before the average completed");

  a_fwd_filled: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && s1.hit && fwd_hit) |-> filled[write_bank][idx])
    else $error("forwarded entry not marked as written");

endmodule
